// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gga_pkg.sv =====
// Package for the GGA field extractor: characters, field numbers, result kinds,
// controller states, command/status structs and the header match step. No dependencies.
package gga_pkg;

  localparam int LINE_CHARS_DEF  = 128;
  localparam int FIELD_CHARS_DEF = 16;

  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  localparam logic [3:0] TOK_LAT = 4'd2;
  localparam logic [3:0] TOK_LON = 4'd4;
  localparam logic [3:0] TOK_ALT = 4'd9;
  localparam logic [3:0] TOK_MAX = 4'd15;

  localparam logic [2:0] PAT_LEN = 3'd5;
  localparam logic [7:0] GGA_PAT  [0:4] = '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [2:0] GGA_FAIL [0:4] = '{3'd0, 3'd0, 3'd1, 3'd1, 3'd0};

  typedef enum logic [1:0] {
    KIND_LAT = 2'd0,
    KIND_LON = 2'd1,
    KIND_ALT = 2'd2,
    KIND_OVF = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAT,
    ST_LON,
    ST_ALT,
    ST_OVF
  } state_t;

  typedef struct packed {
    logic  take;
    logic  clear;
    logic  load;
    logic  slot_inc;
    logic  slot_rst;
    kind_t sel;
  } cmd_t;

  typedef struct packed {
    logic eol;
    logic matched;
    logic ovf;
    logic fld_empty;
    logic fld_final;
    logic out_free;
  } sts_t;

  // one step of the "GPGGA" prefix matcher
  function automatic logic [2:0] gga_match_step(input logic [2:0] p_in, input logic [7:0] c);
    logic [2:0] p;
    logic       done;
    p    = (p_in >= PAT_LEN) ? 3'd0 : p_in;
    done = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (!done) begin
        if (p != 3'd0 && c != GGA_PAT[p]) begin
          p = GGA_FAIL[p - 3'd1];
        end else begin
          done = 1'b1;
        end
      end
    end
    if (c == GGA_PAT[p]) begin
      p = p + 3'd1;
    end
    return p;
  endfunction

endpackage

// ===== hdl/gga_ctrl.sv =====
// Controller FSM of the GGA field extractor: accepts bytes, sequences the drain.
// Depends on gga_pkg.
module gga_ctrl import gga_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.sel      = KIND_LAT;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cmd.slot_rst = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          if (sts.eol && sts.matched) begin
            state_nxt = ST_LAT;
          end else if (sts.ovf) begin
            state_nxt = ST_OVF;
          end
        end
      end
      ST_LAT, ST_LON, ST_ALT: begin
        cmd.sel = (state_r == ST_LAT) ? KIND_LAT :
                  (state_r == ST_LON) ? KIND_LON : KIND_ALT;
        if (sts.fld_empty || (sts.out_free && sts.fld_final)) begin
          cmd.load     = !sts.fld_empty;
          cmd.slot_rst = 1'b1;
          case (state_r)
            ST_LAT:  state_nxt = ST_LON;
            ST_LON:  state_nxt = ST_ALT;
            default: begin
              state_nxt = ST_IDLE;
              cmd.clear = 1'b1;
            end
          endcase
        end else if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.slot_inc = 1'b1;
        end
      end
      ST_OVF: begin
        cmd.sel = KIND_OVF;
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/gga_dp.sv =====
// Datapath of the GGA field extractor: line/field tracking, field buffers,
// drain slot counter and output register. Depends on gga_pkg.
module gga_dp import gga_pkg::*; #(
  parameter int LINE_CHARS  = LINE_CHARS_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  cmd_t       cmd,
  output sts_t       sts,
  input  logic       out_tready,
  output logic       out_tvalid,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  localparam int IDX_W = $clog2(FIELD_CHARS);
  localparam int LEN_W = $clog2(FIELD_CHARS + 1);
  localparam int TOT_W = $clog2(FIELD_CHARS + 2);
  localparam int LL_W  = $clog2(LINE_CHARS);
  localparam logic [LL_W-1:0]  LL_LIMIT = LL_W'(LINE_CHARS - 1);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(FIELD_CHARS);

  logic [LL_W-1:0]  line_len_r, line_len_nxt;
  logic [3:0]       tok_r, tok_nxt;
  logic             in_tok_r, in_tok_nxt;
  logic [2:0]       prog_r, prog_nxt;
  logic             matched_r, matched_nxt;
  logic [LEN_W-1:0] lat_len_r, lat_len_nxt;
  logic [LEN_W-1:0] lon_len_r, lon_len_nxt;
  logic [LEN_W-1:0] alt_len_r, alt_len_nxt;
  logic             lon_chk_r, lon_chk_nxt;
  logic [TOT_W-1:0] slot_r;

  logic [7:0] lat_mem [FIELD_CHARS];
  logic [7:0] lon_mem [FIELD_CHARS];
  logic [7:0] alt_mem [FIELD_CHARS];

  logic             out_vld_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_char_r;
  logic             out_last_r;

  logic             is_eol, ovf, do_clear;
  logic             lat_we, lon_we, alt_we;
  logic [LL_W-1:0]  line_len_inc;
  logic [2:0]       pm;

  logic [LEN_W-1:0] sel_len;
  logic             dotted, rest_empty, fld_final;
  logic [TOT_W-1:0] tot;
  logic [IDX_W-1:0] rd_idx;

  assign is_eol       = (in_byte == CHR_CR) || (in_byte == CHR_LF);
  assign line_len_inc = line_len_r + LL_W'(1);
  assign ovf          = !is_eol && (line_len_inc >= LL_LIMIT);
  assign pm           = gga_match_step(prog_r, in_byte);

  always_comb begin
    line_len_nxt = line_len_r;
    tok_nxt      = tok_r;
    in_tok_nxt   = in_tok_r;
    prog_nxt     = prog_r;
    matched_nxt  = matched_r;
    lat_len_nxt  = lat_len_r;
    lon_len_nxt  = lon_len_r;
    alt_len_nxt  = alt_len_r;
    lon_chk_nxt  = lon_chk_r;
    lat_we       = 1'b0;
    lon_we       = 1'b0;
    alt_we       = 1'b0;
    do_clear     = cmd.clear;
    if (cmd.take) begin
      if (is_eol) begin
        do_clear = !matched_r;
      end else begin
        line_len_nxt = line_len_inc;
        if (!matched_r) begin
          if (pm >= PAT_LEN) begin
            matched_nxt = 1'b1;
            prog_nxt    = 3'd0;
          end else begin
            prog_nxt = pm;
          end
        end
        if (in_byte == CHR_COMMA) begin
          if (in_tok_r) begin
            in_tok_nxt = 1'b0;
            if (tok_r < TOK_MAX) begin
              tok_nxt = tok_r + 4'd1;
            end
          end
        end else begin
          in_tok_nxt = 1'b1;
          if (tok_r == TOK_LAT) begin
            lat_we = (in_byte != CHR_DOT) && (lat_len_r < LEN_FULL);
          end else if (tok_r == TOK_LON) begin
            if (in_byte != CHR_DOT) begin
              lon_chk_nxt = 1'b1;
              lon_we = (lon_chk_r || in_byte != CHR_ZERO) && (lon_len_r < LEN_FULL);
            end
          end else if (tok_r == TOK_ALT) begin
            alt_we = alt_len_r < LEN_FULL;
          end
        end
        if (lat_we) lat_len_nxt = lat_len_r + LEN_W'(1);
        if (lon_we) lon_len_nxt = lon_len_r + LEN_W'(1);
        if (alt_we) alt_len_nxt = alt_len_r + LEN_W'(1);
        do_clear = ovf;
      end
    end
    if (do_clear) begin
      line_len_nxt = '0;
      tok_nxt      = '0;
      in_tok_nxt   = 1'b0;
      prog_nxt     = '0;
      matched_nxt  = 1'b0;
      lat_len_nxt  = '0;
      lon_len_nxt  = '0;
      alt_len_nxt  = '0;
      lon_chk_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r <= '0;
      tok_r      <= '0;
      in_tok_r   <= 1'b0;
      prog_r     <= '0;
      matched_r  <= 1'b0;
      lat_len_r  <= '0;
      lon_len_r  <= '0;
      alt_len_r  <= '0;
      lon_chk_r  <= 1'b0;
    end else begin
      line_len_r <= line_len_nxt;
      tok_r      <= tok_nxt;
      in_tok_r   <= in_tok_nxt;
      prog_r     <= prog_nxt;
      matched_r  <= matched_nxt;
      lat_len_r  <= lat_len_nxt;
      lon_len_r  <= lon_len_nxt;
      alt_len_r  <= alt_len_nxt;
      lon_chk_r  <= lon_chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lat_we) lat_mem[lat_len_r[IDX_W-1:0]] <= in_byte;
    if (lon_we) lon_mem[lon_len_r[IDX_W-1:0]] <= in_byte;
    if (alt_we) alt_mem[alt_len_r[IDX_W-1:0]] <= in_byte;
  end

  // drain: dotted fields put '.' in slot 2 when two or more chars were kept
  always_comb begin
    case (cmd.sel)
      KIND_LAT: begin
        sel_len    = lat_len_r;
        rest_empty = (lon_len_r == '0) && (alt_len_r == '0);
      end
      KIND_LON: begin
        sel_len    = lon_len_r;
        rest_empty = alt_len_r == '0;
      end
      KIND_ALT: begin
        sel_len    = alt_len_r;
        rest_empty = 1'b1;
      end
      default: begin
        sel_len    = '0;
        rest_empty = 1'b1;
      end
    endcase
    dotted    = (cmd.sel == KIND_LAT) || (cmd.sel == KIND_LON);
    tot       = TOT_W'(sel_len) + TOT_W'(dotted && (sel_len >= LEN_W'(2)));
    rd_idx    = (dotted && slot_r > TOT_W'(2)) ? IDX_W'(slot_r - TOT_W'(1)) : IDX_W'(slot_r);
    fld_final = slot_r == (tot - TOT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (cmd.slot_rst) begin
      slot_r <= '0;
    end else if (cmd.slot_inc) begin
      slot_r <= slot_r + TOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind_r <= cmd.sel;
      out_last_r <= (cmd.sel == KIND_OVF) || (fld_final && rest_empty);
      case (cmd.sel)
        KIND_LAT: out_char_r <= (slot_r == TOT_W'(2)) ? CHR_DOT : lat_mem[rd_idx];
        KIND_LON: out_char_r <= (slot_r == TOT_W'(2)) ? CHR_DOT : lon_mem[rd_idx];
        KIND_ALT: out_char_r <= alt_mem[rd_idx];
        default:  out_char_r <= 8'h00;
      endcase
    end
  end

  assign sts.eol       = is_eol;
  assign sts.matched   = matched_r;
  assign sts.ovf       = ovf;
  assign sts.fld_empty = sel_len == '0;
  assign sts.fld_final = fld_final;
  assign sts.out_free  = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_char_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== hdl/gga_sentence_field_extractor.sv =====
// Top level of the GGA sentence field extractor: controller plus datapath.
// Depends on gga_pkg, gga_ctrl, gga_dp and assert_macros.svh.
//
//   channel | dir | tdata         | tuser     | tlast
//   in_     | in  | rx_byte[7:0]  | -         | -
//   out_    | out | out_char[7:0] | kind[1:0] | last
//
// A byte that fills the line is followed by the overflow notice, loaded before
// the next byte is taken. A CR/LF ending a "GPGGA" line drains its non-empty
// fields, one result per cycle when not stalled, via the single output register.
// in_tready is low during a drain; out_tready low stalls the drain in place.
// Synchronous active-low reset clears control state only.
`include "assert_macros.svh"

module gga_sentence_field_extractor import gga_pkg::*; #(
  parameter int LINE_CHARS  = LINE_CHARS_DEF,
  parameter int FIELD_CHARS = FIELD_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);

  cmd_t cmd;
  sts_t sts;

  gga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gga_dp #(
    .LINE_CHARS  (LINE_CHARS),
    .FIELD_CHARS (FIELD_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `ASSERT_IMPL(a_ovf_fmt, out_tvalid && out_tuser == KIND_OVF, out_tlast && out_tdata == 8'h00, "overflow notice malformed")
  `ASSERT_NEXT(a_ovf_blocks, in_tvalid && in_tready && sts.ovf, !in_tready, "input open after overflow")
  `ASSERT_NEXT(a_nomatch_idle, in_tvalid && in_tready && sts.eol && !sts.matched, in_tready, "drain on unmatched line")

endmodule

// ===== verif/gga_field_checker_pkg.sv =====
// Scoreboard for the GGA field extractor bench: predicts the character beats
// each received byte causes and compares them with the block's output.
// Depends on gga_pkg for the result kinds and character constants.
package gga_field_checker_pkg;
  import gga_pkg::*;

  localparam logic [39:0] HEADER_WORD = "GPGGA";

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  class gga_field_checker;
    int unsigned line_len;
    logic [3:0]  field_no;
    bit          in_field;
    logic [39:0] recent;
    bit          header_seen;
    bit          lon_lead_done;
    char_q_t     lat_q;
    char_q_t     lon_q;
    char_q_t     alt_q;
    field_char_t expected_chars[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned lines;
    int unsigned gga_runs;
    int unsigned overflows;

    function new();
      clear_line();
      errors    = 0;
      checked   = 0;
      lines     = 0;
      gga_runs  = 0;
      overflows = 0;
    endfunction

    function void clear_line();
      line_len      = 0;
      field_no      = '0;
      in_field      = 1'b0;
      recent        = '0;
      header_seen   = 1'b0;
      lon_lead_done = 1'b0;
      lat_q.delete();
      lon_q.delete();
      alt_q.delete();
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void queue_char(kind_t k, logic [7:0] c);
      field_char_t r;
      r.kind = k;
      r.ch   = c;
      r.last = 1'b0;
      expected_chars.push_back(r);
    endfunction

    // two kept digits, then the decimal point
    function void queue_coord(kind_t k, char_q_t q);
      foreach (q[i]) begin
        if (i == 2) queue_char(k, CHR_DOT);
        queue_char(k, q[i]);
      end
      if (q.size() == 2) queue_char(k, CHR_DOT);
    endfunction

    function void close_run();
      field_char_t r;
      r = expected_chars.pop_back();
      r.last = 1'b1;
      expected_chars.push_back(r);
    endfunction

    function void take_byte(logic [7:0] c);
      int unsigned run_start;
      if (c == CHR_LF || c == CHR_CR) begin
        lines++;
        if (header_seen) begin
          run_start = expected_chars.size();
          gga_runs++;
          queue_coord(KIND_LAT, lat_q);
          queue_coord(KIND_LON, lon_q);
          foreach (alt_q[i]) queue_char(KIND_ALT, alt_q[i]);
          if (expected_chars.size() > run_start) close_run();
        end
        clear_line();
        return;
      end
      line_len++;
      if (!header_seen) begin
        recent      = {recent[31:0], c};
        header_seen = (recent == HEADER_WORD);
      end
      if (c == CHR_COMMA) begin
        if (in_field) begin
          in_field = 1'b0;
          if (field_no != TOK_MAX) field_no++;
        end
      end else begin
        in_field = 1'b1;
        if (field_no == TOK_LAT) begin
          if (c != CHR_DOT && lat_q.size() < FIELD_CHARS_DEF) lat_q.push_back(c);
        end else if (field_no == TOK_LON) begin
          if (c != CHR_DOT) begin
            if ((lon_lead_done || c != CHR_ZERO) && lon_q.size() < FIELD_CHARS_DEF)
              lon_q.push_back(c);
            lon_lead_done = 1'b1;
          end
        end else if (field_no == TOK_ALT) begin
          if (alt_q.size() < FIELD_CHARS_DEF) alt_q.push_back(c);
        end
      end
      if (line_len >= LINE_CHARS_DEF - 1) begin
        queue_char(KIND_OVF, 8'h00);
        close_run();
        overflows++;
        clear_line();
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(kind_t k, logic [7:0] c, logic l);
      field_char_t e;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected beat kind %0d char 0x%02h last %0b", k, c, l));
        return;
      end
      e = expected_chars.pop_front();
      checked++;
      if (k !== e.kind)
        report($sformatf("beat %0d kind %0d, want %0d", checked, k, e.kind));
      if (c !== e.ch)
        report($sformatf("beat %0d char 0x%02h, want 0x%02h", checked, c, e.ch));
      if (l !== e.last)
        report($sformatf("beat %0d last %0b, want %0b", checked, l, e.last));
    endtask
  endclass

endpackage

// ===== verif/gga_sentence_field_extractor_tb.sv =====
// Testbench for gga_sentence_field_extractor: streams GGA-like sentences, noise
// and overlong lines with random gaps and output stalls, checking every beat.
// Depends on gga_pkg, gga_field_checker_pkg and the RTL under hdl/.
module gga_sentence_field_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gga_pkg::*;
  import gga_field_checker_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_BUDGET = 410;
  localparam int DRAIN_WAIT  = 100;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  gga_field_checker sb = new();

  int          burst_left  = 0;
  int unsigned bytes_sent  = 0;
  int          idle_cycles = 0;
  int          pattern_step = 0;
  bit          held_off    = 1'b0;
  logic [7:0]  line_buf[$];

  gga_sentence_field_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(kind_t'(out_tuser), out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.take_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("** gga_sentence_field_extractor: FAILED **");
        $finish;
      end
    end
  end

  // output side: stall patterns plus one long hold-off
  initial begin
    int mode;
    int span;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        if (!held_off && bytes_sent >= 120) begin
          held_off = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        pattern_step++;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= (pattern_step % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic add_byte(logic [7:0] b);
    line_buf.push_back(b);
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_line_end();
    case ($urandom_range(0, 2))
      0: add_byte(CHR_CR);
      1: add_byte(CHR_LF);
      default: begin
        add_byte(CHR_CR);
        add_byte(CHR_LF);
      end
    endcase
  endtask

  task automatic flush_line();
    while (line_buf.size() > 0) send_byte(line_buf.pop_front());
  endtask

  function automatic logic [7:0] field_byte(bit numeric);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return 8'($urandom_range(0, 255));
    if (sel == 1) return CHR_DOT;
    if (numeric || sel < 8) return 8'(8'h30 + $urandom_range(0, 9));
    return 8'(8'h41 + $urandom_range(0, 25));
  endfunction

  task automatic build_gga_line(bit overlong);
    int n_fields;
    int len;
    int f;
    if ($urandom_range(0, 1)) add_byte("$");
    case ($urandom_range(0, 7))
      0: add_str("GPGPGGA");
      1: add_str("GNGGA");
      2: add_str("xGGPGGA");
      default: add_str("GPGGA");
    endcase
    n_fields = $urandom_range(0, 16);
    for (f = 1; f <= n_fields; f++) begin
      add_byte(CHR_COMMA);
      if ($urandom_range(0, 5) == 0) add_byte(CHR_COMMA);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 7);
      if (f == 4 && $urandom_range(0, 1)) add_byte(CHR_ZERO);
      repeat (len) add_byte(field_byte(f == 2 || f == 4 || f == 9));
    end
    if (overlong)
      while (line_buf.size() < LINE_CHARS_DEF + 8) add_byte(field_byte(1'b0));
    add_line_end();
  endtask

  task automatic run_directed();
    add_byte(CHR_CR);
    add_str("$GPGGA,92,4916.45,N,01231.12,W,1,8,0.9,545.4,M");
    add_byte(CHR_CR);
    add_byte(CHR_LF);
    add_str("xGPGPGGA,,,1,,.0");
    add_byte(CHR_LF);
    add_str("GP");
    add_byte(CHR_LF);
    add_str("GGA,1,22,N,3,E,1,1,1,77");
    add_byte(CHR_CR);
    add_str("GPGGA,t,12,n,5,e,q,q,q,");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_str("9");
    add_byte(CHR_CR);
    flush_line();
    // long fields and more than fifteen fields, just short of the line limit
    add_str("GPGGA,t,12345678901234567890,n,0ABCDEFGHIJKLMNOPQRST,e,a,b,c,");
    add_str("abcdefghijklmnopqrst,10,11,12,13,14,15,16,17,18,19");
    while (line_buf.size() < LINE_CHARS_DEF - 2) add_byte("1");
    add_byte(CHR_CR);
    flush_line();
    // line limit reached, then the tail forms a new line
    add_str("GPGGA,1,2345,N,");
    while (line_buf.size() < LINE_CHARS_DEF + 2) add_byte(8'(8'h61 + line_buf.size() % 26));
    add_str(",7");
    add_byte(CHR_LF);
    flush_line();
  endtask

  task automatic run_random();
    int sel;
    int len;
    while (bytes_sent < ITEM_BUDGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) begin
        build_gga_line(1'b0);
      end else if (sel < 17) begin
        len = $urandom_range(1, 24);
        repeat (len) add_byte(8'($urandom_range(0, 255)));
        add_line_end();
      end else if (sel < 19) begin
        // truncated sentence running into the next one
        add_str("GPGG");
        add_byte(CHR_COMMA);
        add_byte(field_byte(1'b1));
      end else begin
        build_gga_line($urandom_range(0, 1));
      end
      flush_line();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected beats never came", sb.pending()));
    $display("sent %0d bytes in %0d lines: %0d header lines drained, %0d line overflows",
             bytes_sent, sb.lines, sb.gga_runs, sb.overflows);
    $display("checked %0d output beats, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("** gga_sentence_field_extractor: PASSED **");
    end else begin
      $display("** gga_sentence_field_extractor: FAILED **");
    end
    $finish;
  end

endmodule
